// File: hdl/ctp_pkg.sv
// Shared constants, tables and types of the CORDIC Cartesian-to-polar converter.
`default_nettype none
package ctp_pkg;

    localparam int CTP_COORD_WIDTH = 16;
    localparam int CTP_ITERATIONS  = 16;
    localparam int CTP_GUARD       = 16;
    localparam int CTP_HEAD        = 3;
    localparam int CTP_ZW          = 32;
    localparam int CTP_PROD_W      = 64;
    localparam int CTP_TAB_DEPTH   = 32;
    localparam int CTP_GAIN_DEPTH  = 16;

    localparam logic signed [CTP_ZW-1:0] CTP_DEG180   = 32'sd188743680;
    localparam logic signed [CTP_ZW-1:0] CTP_ANG_BIAS = 32'sd2048;
    localparam logic signed [CTP_ZW-1:0] CTP_ANG_MAX  = 32'sd46080;
    localparam logic signed [CTP_ZW-1:0] CTP_ANG_MIN  = -32'sd46080;
    localparam int                       CTP_ANG_SHIFT = 12;

    localparam logic signed [16:0] CTP_OUT180 = 17'sd46080;
    localparam logic signed [16:0] CTP_OUT90  = 17'sd23040;
    localparam logic [15:0]        CTP_RADIUS_MAX = 16'hFFFF;

    localparam logic [2:0] CTP_QUAD_AXIS = 3'd0;
    localparam logic [2:0] CTP_QUAD_1    = 3'd1;
    localparam logic [2:0] CTP_QUAD_2    = 3'd2;
    localparam logic [2:0] CTP_QUAD_3    = 3'd3;
    localparam logic [2:0] CTP_QUAD_4    = 3'd4;

    typedef logic [31:0] t_atan_tab [CTP_TAB_DEPTH];
    typedef logic [31:0] t_gain_tab [CTP_GAIN_DEPTH];

    localparam t_atan_tab CTP_ATAN = '{
        32'd47185920, 32'd27855475, 32'd14718068, 32'd7471121, 32'd3750058,
        32'd1876857, 32'd938658, 32'd469357, 32'd234682, 32'd117342, 32'd58671,
        32'd29335, 32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458,
        32'd229, 32'd115, 32'd57, 32'd29, 32'd14, 32'd7, 32'd4, 32'd2, 32'd1,
        32'd0, 32'd0, 32'd0, 32'd0, 32'd0
    };

    localparam t_gain_tab CTP_INV_GAIN = '{
        32'd3037000500, 32'd2716375826, 32'd2635271635, 32'd2614921742,
        32'd2609829388, 32'd2608555990, 32'd2608237621, 32'd2608158028,
        32'd2608138129, 32'd2608133154, 32'd2608131911, 32'd2608131600,
        32'd2608131522, 32'd2608131503, 32'd2608131498, 32'd2608131496
    };

    typedef struct packed {
        logic [2:0]         quad;
        logic               special;
        logic [15:0]        sp_radius;
        logic signed [16:0] sp_angle;
    } t_side;

endpackage
`default_nettype wire

// File: hdl/ctp_pre.sv
// Input cell: quadrant, axis cases and turn of the vector into the right half-plane.
`default_nettype none
module ctp_pre #(
    parameter int COORD_WIDTH = 16,
    parameter int XW          = 35
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [COORD_WIDTH-1:0] i_x_coord,
    input  wire logic signed [COORD_WIDTH-1:0] i_y_coord,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [XW-1:0]               o_x,
    output logic signed [XW-1:0]               o_y,
    output logic signed [ctp_pkg::CTP_ZW-1:0]  o_z,
    output ctp_pkg::t_side                     o_side
);
    import ctp_pkg::*;

    logic                    r_valid, n_valid;
    logic                    load;
    logic signed [XW-1:0]    r_x, r_y, n_x, n_y;
    logic signed [CTP_ZW-1:0] r_z, n_z;
    t_side                   r_side, n_side;
    logic signed [COORD_WIDTH:0] sx, sy, ax, ay;
    logic [63:0]             ax_ext, ay_ext;
    logic signed [XW-1:0]    cx, cy;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_valid = load || (r_valid && !i_ready);

        sx = {i_x_coord[COORD_WIDTH-1], i_x_coord};
        sy = {i_y_coord[COORD_WIDTH-1], i_y_coord};
        ax = sx[COORD_WIDTH] ? -sx : sx;
        ay = sy[COORD_WIDTH] ? -sy : sy;
        ax_ext = {{(63 - COORD_WIDTH){1'b0}}, ax};
        ay_ext = {{(63 - COORD_WIDTH){1'b0}}, ay};

        n_side.quad = CTP_QUAD_AXIS;
        if (i_x_coord > 0 && i_y_coord > 0) begin
            n_side.quad = CTP_QUAD_1;
        end else if (i_x_coord < 0 && i_y_coord > 0) begin
            n_side.quad = CTP_QUAD_2;
        end else if (i_x_coord < 0 && i_y_coord < 0) begin
            n_side.quad = CTP_QUAD_3;
        end else if (i_x_coord > 0 && i_y_coord < 0) begin
            n_side.quad = CTP_QUAD_4;
        end

        n_side.special   = 1'b0;
        n_side.sp_radius = '0;
        n_side.sp_angle  = '0;
        if (i_y_coord == 0) begin
            n_side.special   = 1'b1;
            n_side.sp_radius = (ax_ext > 64'd65535) ? CTP_RADIUS_MAX : ax_ext[15:0];
            n_side.sp_angle  = i_x_coord < 0 ? CTP_OUT180 : 17'sd0;
        end else if (i_x_coord == 0) begin
            n_side.special   = 1'b1;
            n_side.sp_radius = (ay_ext > 64'd65535) ? CTP_RADIUS_MAX : ay_ext[15:0];
            n_side.sp_angle  = i_y_coord > 0 ? CTP_OUT90 : -CTP_OUT90;
        end

        cx = {{CTP_HEAD{i_x_coord[COORD_WIDTH-1]}}, i_x_coord, {CTP_GUARD{1'b0}}};
        cy = {{CTP_HEAD{i_y_coord[COORD_WIDTH-1]}}, i_y_coord, {CTP_GUARD{1'b0}}};
        if (cx < 0) begin
            n_x = -cx;
            n_y = -cy;
            n_z = (cy > 0) ? CTP_DEG180 : -CTP_DEG180;
        end else begin
            n_x = cx;
            n_y = cy;
            n_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule
`default_nettype wire

// File: hdl/ctp_cell.sv
// One CORDIC vectoring micro-rotation cell with its own word register.
`default_nettype none
module ctp_cell #(
    parameter int XW    = 35,
    parameter int STAGE = 0
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [XW-1:0]              i_x,
    input  wire logic signed [XW-1:0]              i_y,
    input  wire logic signed [ctp_pkg::CTP_ZW-1:0] i_z,
    input  wire ctp_pkg::t_side                    i_side,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [XW-1:0]                   o_x,
    output logic signed [XW-1:0]                   o_y,
    output logic signed [ctp_pkg::CTP_ZW-1:0]      o_z,
    output ctp_pkg::t_side                         o_side
);
    import ctp_pkg::*;

    localparam logic signed [CTP_ZW-1:0] ATAN = CTP_ATAN[STAGE];

    logic                     r_valid, n_valid;
    logic                     load;
    logic signed [XW-1:0]     r_x, r_y, n_x, n_y, dx, dy;
    logic signed [CTP_ZW-1:0] r_z, n_z;
    t_side                    r_side;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_valid = load || (r_valid && !i_ready);
        dx = i_y >>> STAGE;
        dy = i_x >>> STAGE;
        if (!i_y[XW-1]) begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + ATAN;
        end else begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule
`default_nettype wire

// File: hdl/ctp_gain.sv
// Output cells: gain correction by partial products, rounding, clamping and result register.
`default_nettype none
module ctp_gain #(
    parameter int XW         = 35,
    parameter int ITERATIONS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [XW-1:0]              i_x,
    input  wire logic signed [ctp_pkg::CTP_ZW-1:0] i_z,
    input  wire ctp_pkg::t_side                    i_side,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [2:0]                             o_quadrant,
    output logic [15:0]                            o_radius,
    output logic signed [16:0]                     o_angle_deg
);
    import ctp_pkg::*;

    localparam int GAIN_IDX = (ITERATIONS > CTP_GAIN_DEPTH ? CTP_GAIN_DEPTH : ITERATIONS) - 1;
    localparam logic [31:0] GAIN = CTP_INV_GAIN[GAIN_IDX];

    logic                     r_va, n_va, r_vb, n_vb;
    logic                     a_ready, b_ready, load_a, load_b;
    logic [CTP_PROD_W-1:0]    ux;
    logic [CTP_PROD_W-1:0]    r_hi_prod, r_lo_prod, n_hi_prod, n_lo_prod;
    logic signed [CTP_ZW-1:0] zr;
    logic signed [16:0]       r_angle_a, n_angle_a;
    t_side                    r_side_a;
    logic [64:0]              psum, prnd;
    logic [48:0]              rshift;
    logic [15:0]              n_radius, r_radius;
    logic signed [16:0]       r_angle_b;
    logic [2:0]               r_quad;

    assign b_ready = !r_vb || i_ready;
    assign a_ready = !r_va || b_ready;
    assign o_ready = a_ready;
    assign load_a  = i_valid && a_ready;
    assign load_b  = r_va && b_ready;

    always_comb begin
        n_va = load_a || (r_va && !b_ready);
        n_vb = load_b || (r_vb && !i_ready);

        ux = {{(CTP_PROD_W - XW){1'b0}}, i_x};
        n_hi_prod = {32'b0, ux[63:32]} * {32'b0, GAIN};
        n_lo_prod = {32'b0, ux[31:0]} * {32'b0, GAIN};

        zr = (i_z + CTP_ANG_BIAS) >>> CTP_ANG_SHIFT;
        if (i_side.special) begin
            n_angle_a = i_side.sp_angle;
        end else if (zr > CTP_ANG_MAX) begin
            n_angle_a = CTP_OUT180;
        end else if (zr < CTP_ANG_MIN) begin
            n_angle_a = -CTP_OUT180;
        end else begin
            n_angle_a = zr[16:0];
        end

        psum   = {1'b0, r_hi_prod} + {33'b0, r_lo_prod[63:32]};
        prnd   = psum + (65'd1 << (CTP_GUARD - 1));
        rshift = prnd[64:CTP_GUARD];
        if (r_side_a.special) begin
            n_radius = r_side_a.sp_radius;
        end else if (|rshift[48:16]) begin
            n_radius = CTP_RADIUS_MAX;
        end else begin
            n_radius = rshift[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= n_va;
            r_vb <= n_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_a) begin
            r_hi_prod <= n_hi_prod;
            r_lo_prod <= n_lo_prod;
            r_angle_a <= n_angle_a;
            r_side_a  <= i_side;
        end
        if (load_b) begin
            r_radius  <= n_radius;
            r_angle_b <= r_angle_a;
            r_quad    <= r_side_a.quad;
        end
    end

    assign o_valid     = r_vb;
    assign o_quadrant  = r_quad;
    assign o_radius    = r_radius;
    assign o_angle_deg = r_angle_b;

endmodule
`default_nettype wire

// File: hdl/cartesian_to_polar.sv
// Top level of the pipelined CORDIC Cartesian-to-polar converter.
// The pipeline runs from acceptance to o_valid through one input cell,
// ITERATIONS rotation cells and two gain and output cells.
// Throughput is one word per cycle while o_ready is high; every cell holds one word
// and passes it on as soon as its neighbor has room, so bubbles close up under output stalls.
// A synchronous active-low reset clears every valid flag; data registers keep their contents.
`default_nettype none
module cartesian_to_polar #(
    parameter int COORD_WIDTH = ctp_pkg::CTP_COORD_WIDTH,
    parameter int ITERATIONS  = ctp_pkg::CTP_ITERATIONS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [COORD_WIDTH-1:0] i_x_coord,
    input  wire logic signed [COORD_WIDTH-1:0] i_y_coord,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [2:0]                         o_quadrant,
    output logic [15:0]                        o_radius,
    output logic signed [16:0]                 o_angle_deg
);
    import ctp_pkg::*;

    localparam int XW = COORD_WIDTH + CTP_GUARD + CTP_HEAD;

    logic                     w_valid [ITERATIONS+1];
    logic                     w_ready [ITERATIONS+1];
    logic signed [XW-1:0]     w_x     [ITERATIONS+1];
    logic signed [XW-1:0]     w_y     [ITERATIONS+1];
    logic signed [CTP_ZW-1:0] w_z     [ITERATIONS+1];
    t_side                    w_side  [ITERATIONS+1];

    ctp_pre #(
        .COORD_WIDTH (COORD_WIDTH),
        .XW          (XW)
    ) u_pre (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_x_coord (i_x_coord),
        .i_y_coord (i_y_coord),
        .o_valid   (w_valid[0]),
        .i_ready   (w_ready[0]),
        .o_x       (w_x[0]),
        .o_y       (w_y[0]),
        .o_z       (w_z[0]),
        .o_side    (w_side[0])
    );

    for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
        ctp_cell #(
            .XW    (XW),
            .STAGE (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_x     (w_x[k]),
            .i_y     (w_y[k]),
            .i_z     (w_z[k]),
            .i_side  (w_side[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_x     (w_x[k+1]),
            .o_y     (w_y[k+1]),
            .o_z     (w_z[k+1]),
            .o_side  (w_side[k+1])
        );
    end

    ctp_gain #(
        .XW         (XW),
        .ITERATIONS (ITERATIONS)
    ) u_gain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid[ITERATIONS]),
        .o_ready     (w_ready[ITERATIONS]),
        .i_x         (w_x[ITERATIONS]),
        .i_z         (w_z[ITERATIONS]),
        .i_side      (w_side[ITERATIONS]),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_quadrant  (o_quadrant),
        .o_radius    (o_radius),
        .o_angle_deg (o_angle_deg)
    );

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output valid after reset.");

    a_axis_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_quadrant == CTP_QUAD_AXIS) |->
            (o_angle_deg == 17'sd0 || o_angle_deg == CTP_OUT90 ||
             o_angle_deg == -CTP_OUT90 || o_angle_deg == CTP_OUT180))
        else $error("Axis point with an angle off the axes.");

    a_upper_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_quadrant == CTP_QUAD_1 || o_quadrant == CTP_QUAD_2)) |->
            !o_angle_deg[16])
        else $error("Negative angle for a point above the x axis.");

    a_third_quad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_quadrant == CTP_QUAD_3) |-> o_angle_deg[16])
        else $error("Non-negative angle for a third-quadrant point.");

endmodule
`default_nettype wire
